// ===== src/tgad_pkg.sv =====
package tgad_pkg;

  // decoder phases
  typedef enum logic [2:0] {
    PH_SIG  = 3'd0,
    PH_HDR  = 3'd1,
    PH_PKT  = 3'd2,
    PH_PIX  = 3'd3,
    PH_DONE = 3'd4,
    PH_HALT = 3'd5
  } phase_t;

  // result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // error codes
  localparam logic [1:0] ERR_SIG   = 2'd0;
  localparam logic [1:0] ERR_SIZE  = 2'd1;
  localparam logic [1:0] ERR_OVER  = 2'd2;
  localparam logic [1:0] ERR_TRUNC = 2'd3;

  // file layout
  localparam int          HDR_IDX_W     = 4;
  localparam logic [3:0]  SIG_TYPE_IDX  = 4'd2;
  localparam logic [3:0]  SIG_LAST_IDX  = 4'd11;
  localparam logic [3:0]  HDR_WLO_IDX   = 4'd0;
  localparam logic [3:0]  HDR_WHI_IDX   = 4'd1;
  localparam logic [3:0]  HDR_HLO_IDX   = 4'd2;
  localparam logic [3:0]  HDR_HHI_IDX   = 4'd3;
  localparam logic [3:0]  HDR_DEPTH_IDX = 4'd4;
  localparam logic [7:0]  TYPE_RAW      = 8'd2;
  localparam logic [7:0]  TYPE_RLE      = 8'd10;
  localparam logic [7:0]  DEPTH_24      = 8'd24;
  localparam logic [7:0]  DEPTH_32      = 8'd32;
  localparam logic [1:0]  LAST_BYTE_24  = 2'd2;
  localparam logic [1:0]  LAST_BYTE_32  = 2'd3;

  // result queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] width;
    logic [15:0] height;
    logic        has_alpha;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  run_length;
    logic [1:0]  error_code;
    logic        image_done;
  } result_t;

endpackage

// ===== src/tga_image_stream_decoder_unit.sv =====
// A result is written into the result queue when the byte that causes it is accepted.
// Throughput: one byte per cycle; a byte yields up to two results, which wait in a
// four-entry result queue, and in_tready drops while fewer than two slots are free.
// Reset: synchronous, active low; clears the decoder state and empties the queue.
// A byte marked with in_tlast also returns the decoder to its start state.
module tga_image_stream_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // stream_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [15:0] width, [31:16] height, [32] has_alpha,
                                  // [40:33] red, [48:41] green, [56:49] blue,
                                  // [64:57] alpha, [72:65] run_length,
                                  // [74:73] error_code, [79:75] zero
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast   // image_done
);

  localparam int QD  = tgad_pkg::QUEUE_DEPTH;
  localparam int QPW = tgad_pkg::QPTR_W;
  localparam int QCW = tgad_pkg::QCNT_W;

  tgad_pkg::phase_t phase_r, phase_nxt;
  logic [tgad_pkg::HDR_IDX_W-1:0] hdr_idx_r, hdr_idx_nxt;
  logic        comp_r, comp_nxt;
  logic [15:0] width_r, width_nxt;
  logic [15:0] height_r, height_nxt;
  logic        four_r, four_nxt;
  logic [31:0] remain_r, remain_nxt;
  logic [7:0]  left_r, left_nxt;
  logic        is_run_r, is_run_nxt;
  logic [1:0]  cidx_r, cidx_nxt;
  logic [7:0]  cb_r [3];
  logic        cb_we;

  logic        in_fire, out_fire;
  logic [7:0]  b;
  logic [31:0] area;
  logic [1:0]  last_idx;
  logic [7:0]  pix_count;
  logic [7:0]  left_dec;
  logic [31:0] remain_after;
  logic        excess;
  logic        err_v;
  logic [1:0]  err_code;
  logic        prim_v, sec_v;
  tgad_pkg::result_t prim, sec, res0;

  tgad_pkg::result_t q_r [QD];
  logic [QPW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0] cnt_r;
  logic [1:0]     push_cnt;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;
  assign b        = in_tdata;
  assign area     = width_r * height_r;
  assign last_idx = four_r ? tgad_pkg::LAST_BYTE_32 : tgad_pkg::LAST_BYTE_24;
  assign left_dec = (left_r != 8'd0) ? left_r - 8'd1 : 8'd0;

  always_comb begin
    phase_nxt    = phase_r;
    hdr_idx_nxt  = hdr_idx_r;
    comp_nxt     = comp_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    four_nxt     = four_r;
    remain_nxt   = remain_r;
    left_nxt     = left_r;
    is_run_nxt   = is_run_r;
    cidx_nxt     = cidx_r;
    cb_we        = 1'b0;
    err_v        = 1'b0;
    err_code     = tgad_pkg::ERR_SIG;
    prim_v       = 1'b0;
    prim         = '0;
    sec_v        = 1'b0;
    sec          = '0;
    pix_count    = 8'd1;
    excess       = 1'b0;
    remain_after = remain_r - 32'd1;
    if (in_fire) begin
      unique case (phase_r)
        tgad_pkg::PH_SIG: begin
          if (hdr_idx_r == tgad_pkg::SIG_TYPE_IDX) begin
            if (b == tgad_pkg::TYPE_RAW) comp_nxt = 1'b0;
            else if (b == tgad_pkg::TYPE_RLE) comp_nxt = 1'b1;
            else err_v = 1'b1;
          end else if (b != 8'd0) begin
            err_v = 1'b1;
          end
          err_code = tgad_pkg::ERR_SIG;
          if (!err_v) begin
            if (hdr_idx_r == tgad_pkg::SIG_LAST_IDX) begin
              phase_nxt   = tgad_pkg::PH_HDR;
              hdr_idx_nxt = '0;
            end else begin
              hdr_idx_nxt = hdr_idx_r + 1'b1;
            end
          end
        end
        tgad_pkg::PH_HDR: begin
          err_code = tgad_pkg::ERR_SIZE;
          unique case (hdr_idx_r)
            tgad_pkg::HDR_WLO_IDX: width_nxt  = {8'd0, b};
            tgad_pkg::HDR_WHI_IDX: width_nxt  = {b, width_r[7:0]};
            tgad_pkg::HDR_HLO_IDX: height_nxt = {8'd0, b};
            tgad_pkg::HDR_HHI_IDX: height_nxt = {b, height_r[7:0]};
            tgad_pkg::HDR_DEPTH_IDX: begin
              four_nxt = (b == tgad_pkg::DEPTH_32);
              err_v = (width_r == 16'd0) || (height_r == 16'd0) ||
                      ((b != tgad_pkg::DEPTH_24) && (b != tgad_pkg::DEPTH_32));
            end
            default: begin
              // descriptor byte: value ignored, emit header
              prim_v          = 1'b1;
              prim.kind       = tgad_pkg::KIND_HEADER;
              prim.width      = width_r;
              prim.height     = height_r;
              prim.has_alpha  = four_r;
              remain_nxt      = area;
              cidx_nxt        = 2'd0;
              left_nxt        = 8'd0;
              is_run_nxt      = 1'b0;
              phase_nxt       = comp_r ? tgad_pkg::PH_PKT : tgad_pkg::PH_PIX;
            end
          endcase
          if (!err_v && (hdr_idx_r <= tgad_pkg::HDR_DEPTH_IDX)) hdr_idx_nxt = hdr_idx_r + 1'b1;
        end
        tgad_pkg::PH_PKT: begin
          // raw: low bits + 1; run: value - 127, which is the same sum
          is_run_nxt = b[7];
          left_nxt   = {1'b0, b[6:0]} + 8'd1;
          cidx_nxt   = 2'd0;
          phase_nxt  = tgad_pkg::PH_PIX;
        end
        tgad_pkg::PH_PIX: begin
          if (cidx_r < last_idx) begin
            cb_we    = 1'b1;
            cidx_nxt = cidx_r + 2'd1;
          end else begin
            cidx_nxt = 2'd0;
            if (comp_r && is_run_r) begin
              excess    = {24'd0, left_r} > remain_r;
              pix_count = excess ? remain_r[7:0] : left_r;
              left_nxt  = 8'd0;
            end else begin
              pix_count = 8'd1;
              if (comp_r) left_nxt = left_dec;
              excess = comp_r && (remain_r == 32'd1) && (left_dec != 8'd0);
            end
            remain_after    = remain_r - {24'd0, pix_count};
            remain_nxt      = remain_after;
            prim_v          = 1'b1;
            prim.kind       = tgad_pkg::KIND_PIXEL;
            prim.has_alpha  = four_r;
            prim.red        = four_r ? cb_r[2] : b;
            prim.green      = cb_r[1];
            prim.blue       = cb_r[0];
            prim.alpha      = four_r ? b : 8'd0;
            prim.run_length = pix_count;
            prim.image_done = (remain_after == 32'd0);
            err_code        = tgad_pkg::ERR_OVER;
            err_v           = excess;
            if (!excess) begin
              if (remain_after == 32'd0) phase_nxt = tgad_pkg::PH_DONE;
              else if (comp_r && (left_nxt == 8'd0)) phase_nxt = tgad_pkg::PH_PKT;
            end
          end
        end
        default: ;
      endcase

      if (err_v) begin
        phase_nxt      = tgad_pkg::PH_HALT;
        sec_v          = 1'b1;
        sec.kind       = tgad_pkg::KIND_ERROR;
        sec.error_code = err_code;
      end

      if (in_tlast) begin
        if (!err_v && (phase_nxt != tgad_pkg::PH_DONE) && (phase_nxt != tgad_pkg::PH_HALT)) begin
          sec_v          = 1'b1;
          sec.kind       = tgad_pkg::KIND_ERROR;
          sec.error_code = tgad_pkg::ERR_TRUNC;
        end
        // back to start for the next file
        phase_nxt   = tgad_pkg::PH_SIG;
        hdr_idx_nxt = '0;
        comp_nxt    = 1'b0;
        width_nxt   = 16'd0;
        height_nxt  = 16'd0;
        four_nxt    = 1'b0;
        remain_nxt  = 32'd0;
        left_nxt    = 8'd0;
        is_run_nxt  = 1'b0;
        cidx_nxt    = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= tgad_pkg::PH_SIG;
      hdr_idx_r <= '0;
      comp_r   <= 1'b0;
      width_r  <= 16'd0;
      height_r <= 16'd0;
      four_r   <= 1'b0;
      remain_r <= 32'd0;
      left_r   <= 8'd0;
      is_run_r <= 1'b0;
      cidx_r   <= 2'd0;
    end else begin
      phase_r  <= phase_nxt;
      hdr_idx_r <= hdr_idx_nxt;
      comp_r   <= comp_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      four_r   <= four_nxt;
      remain_r <= remain_nxt;
      left_r   <= left_nxt;
      is_run_r <= is_run_nxt;
      cidx_r   <= cidx_nxt;
    end
  end

  // hold the stored color bytes of the pixel in flight
  always_ff @(posedge clk) begin
    if (cb_we) cb_r[cidx_r] <= b;
  end

  // result queue: up to two pushes and one pop per cycle
  assign res0      = prim_v ? prim : sec;
  assign push_cnt  = {1'b0, prim_v} + {1'b0, sec_v};
  assign in_tready = (cnt_r <= QCW'(QD - 2));

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) q_r[wr_ptr_r] <= res0;
    if (push_cnt == 2'd2) q_r[wr_ptr_r + QPW'(1)] <= sec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QPW'(push_cnt);
      if (out_fire) rd_ptr_r <= rd_ptr_r + QPW'(1);
      cnt_r <= cnt_r + QCW'(push_cnt) - QCW'(out_fire);
    end
  end

  assign out_tvalid = (cnt_r != '0);
  assign out_tuser  = q_r[rd_ptr_r].kind;
  assign out_tlast  = q_r[rd_ptr_r].image_done;
  assign out_tdata  = {5'd0,
                       q_r[rd_ptr_r].error_code,
                       q_r[rd_ptr_r].run_length,
                       q_r[rd_ptr_r].alpha,
                       q_r[rd_ptr_r].blue,
                       q_r[rd_ptr_r].green,
                       q_r[rd_ptr_r].red,
                       q_r[rd_ptr_r].has_alpha,
                       q_r[rd_ptr_r].height,
                       q_r[rd_ptr_r].width};

endmodule
